>>> src/falmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falmt_pkg: shared definitions for the LRU miss tracker
// Default sizes, field widths, the sequencer state type and the control
// bundle that drives each cell of the recency stack.
// ----------------------------------------------------------------------------
package falmt_pkg;

    // Default geometry of the tracked cache.
    localparam int LINES_DEF            = 64;
    localparam int LINE_OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF        = 48;

    // Fixed field widths.
    localparam int CFG_W  = 7;
    localparam int SIZE_W = 7;

    // Number of lines taking part after reset.
    localparam int LINES_RESET = 64;

    // Which block of the request is being looked up.
    typedef enum logic {
        ST_FIRST,
        ST_SECOND
    } t_state;

    // Per-cell control: clear drops the entry, shift takes the neighbor's entry.
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

>>> src/falmt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falmt request and response channels
// Valid/ready channels carrying a memory reference in and a miss report out.
// ----------------------------------------------------------------------------
interface falmt_req_if #(
    parameter int ADDR_BITS = falmt_pkg::ADDR_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [ADDR_BITS-1:0]         address;
    logic [falmt_pkg::SIZE_W-1:0] access_bytes;

    modport source (output valid, output address, output access_bytes, input ready);
    modport sink   (input valid, input address, input access_bytes, output ready);
endinterface

interface falmt_rsp_if;
    logic valid;
    logic ready;
    logic miss;
    logic two_blocks;

    modport source (output valid, output miss, output two_blocks, input ready);
    modport sink   (input valid, input miss, input two_blocks, output ready);
endinterface

>>> src/falmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falmt_cell: one position of the LRU recency stack
// Holds one block tag and its valid bit, compares it against the lookup tag
// and takes its upper neighbor's entry when the stack shifts down.
// ----------------------------------------------------------------------------
module falmt_cell #(
    parameter int TAG_W = falmt_pkg::ADDR_BITS_DEF - falmt_pkg::LINE_OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  falmt_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_active,
    input  logic [TAG_W-1:0]      i_lookup,
    input  logic                  i_up_valid,
    input  logic [TAG_W-1:0]      i_up_tag,
    output logic                  o_valid,
    output logic [TAG_W-1:0]      o_tag,
    output logic                  o_hit
);
    import falmt_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic [TAG_W-1:0] r_tag;

    // A clear wins over a shift so a register write leaves the stack empty.
    always_comb begin
        priority if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_up_valid;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The tag is only looked at while the entry is valid.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_tag <= i_up_tag;
        end
    end

    // Only cells inside the configured line count can hit.
    assign o_hit   = i_active && r_valid && (r_tag == i_lookup);
    assign o_valid = r_valid;
    assign o_tag   = r_tag;

endmodule

>>> src/fully_assoc_lru_miss_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_miss_tracker: fully associative LRU cache miss tracker
// Flow: an accepted request is held in the request stage and its result in the
//   output register; a two-line reference is looked up in ST_FIRST, then in
//   ST_SECOND, and the next request waits for both. Throughput: 1 request per
//   cycle for single-line ones unless the output stalls; one pass through the recency stack per line lookup.
// Reset: all lines invalid, 64 lines in use; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fully_assoc_lru_miss_tracker #(
    parameter int LINES            = falmt_pkg::LINES_DEF,
    parameter int LINE_OFFSET_BITS = falmt_pkg::LINE_OFFSET_BITS_DEF,
    parameter int ADDR_BITS        = falmt_pkg::ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [falmt_pkg::CFG_W-1:0] i_cfg_wdata,
    falmt_req_if.sink                   i_req,
    falmt_rsp_if.source                 o_rsp
);
    import falmt_pkg::*;

    localparam int TAG_W = ADDR_BITS - LINE_OFFSET_BITS;
    localparam int CMP_W = (LINE_OFFSET_BITS + 2 > SIZE_W + 1) ?
                           LINE_OFFSET_BITS + 2 : SIZE_W + 1;
    localparam logic [CMP_W-1:0] LINE_BYTES = {{(CMP_W-1){1'b0}}, 1'b1} << LINE_OFFSET_BITS;

    // Request stage.
    logic             r_req_vld;
    logic             n_req_vld;
    logic [TAG_W-1:0] r_blk1;
    logic [TAG_W-1:0] r_blk2;
    logic             r_two;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic   r_miss1;
    logic   w_fire;
    logic   w_done;
    logic   w_out_free;

    // Output register.
    logic r_out_vld;
    logic n_out_vld;
    logic r_out_miss;
    logic r_out_two;

    // Lines in use, as a mask over the stack positions.
    logic [LINES-1:0] r_active;
    logic [LINES-1:0] n_active;

    // Block split of the incoming reference.
    logic [CMP_W-1:0]            w_size_ext;
    logic [LINE_OFFSET_BITS-1:0] w_off;
    logic [LINE_OFFSET_BITS:0]   w_off_sum;
    logic [TAG_W-1:0]            w_blk1;
    logic [TAG_W-1:0]            w_blk2;
    logic                        w_two;

    // Stack signals.
    logic [TAG_W-1:0] w_touch_tag;
    logic [LINES-1:0] w_hit_vec;
    logic [LINES-1:0] w_suffix_hit;
    logic [LINES-1:0] w_valid_q;
    logic [TAG_W-1:0] w_tag_q [LINES];
    logic             w_any_hit;

    // Clamp the size to 1..line bytes and find the offset of the last byte.
    always_comb begin
        w_size_ext = CMP_W'(i_req.access_bytes);
        priority if (w_size_ext == '0) begin
            w_off = '0;
        end else if (w_size_ext > LINE_BYTES) begin
            w_off = LINE_OFFSET_BITS'(LINE_BYTES - 1'b1);
        end else begin
            w_off = LINE_OFFSET_BITS'(w_size_ext - 1'b1);
        end
        w_off_sum = {1'b0, i_req.address[LINE_OFFSET_BITS-1:0]} + {1'b0, w_off};
        w_two     = w_off_sum[LINE_OFFSET_BITS];
        w_blk1    = i_req.address[ADDR_BITS-1:LINE_OFFSET_BITS];
        w_blk2    = w_blk1 + TAG_W'(w_two);
    end

    // Sequencer outputs: when the stack is stepped and when a request completes.
    always_comb begin
        w_out_free = !r_out_vld || o_rsp.ready;
        unique case (r_state)
            ST_FIRST: begin
                w_fire = r_req_vld && (r_two || w_out_free);
                w_done = w_fire && !r_two;
            end
            ST_SECOND: begin
                w_fire = r_req_vld && w_out_free;
                w_done = w_fire;
            end
            default: begin
                w_fire = 1'b0;
                w_done = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FIRST: begin
                if (w_fire && r_two) begin
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: begin
                if (w_fire) begin
                    n_state = ST_FIRST;
                end
            end
            default: begin
                n_state = ST_FIRST;
            end
        endcase
    end

    assign i_req.ready = !r_req_vld || w_done;

    // Request stage and output register control.
    always_comb begin
        n_req_vld = r_req_vld;
        if (i_req.valid && i_req.ready) begin
            n_req_vld = 1'b1;
        end else if (w_done) begin
            n_req_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (w_done) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Line mask from the register: at least two lines, at most the stack depth.
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            n_active[k] = (k < 2) || (int'(i_cfg_wdata) > k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_state   <= ST_FIRST;
            r_out_vld <= 1'b0;
            for (int k = 0; k < LINES; k++) begin
                r_active[k] <= (k < LINES_RESET);
            end
        end else begin
            r_req_vld <= n_req_vld;
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_active <= n_active;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_blk1 <= w_blk1;
            r_blk2 <= w_blk2;
            r_two  <= w_two;
        end
        if (w_fire && r_state == ST_FIRST) begin
            r_miss1 <= !w_any_hit;
        end
        if (w_done) begin
            r_out_miss <= !w_any_hit || (r_state == ST_SECOND && r_miss1);
            r_out_two  <= r_two;
        end
    end

    assign w_touch_tag = (r_state == ST_SECOND) ? r_blk2 : r_blk1;
    assign w_any_hit   = |w_hit_vec;

    // Recency stack: position 0 is most recent, the last active one is the victim.
    // A lookup shifts every position down to the hit, or all of them on a miss,
    // and the looked-up block enters at the top.
    for (genvar k = 0; k < LINES; k++) begin : g_stack
        t_cell_ctl        w_ctl;
        logic             w_up_valid;
        logic [TAG_W-1:0] w_up_tag;

        assign w_suffix_hit[k] = |w_hit_vec[LINES-1:k];
        assign w_ctl.clear     = i_cfg_we;
        assign w_ctl.shift     = w_fire && (!w_any_hit || w_suffix_hit[k]);

        if (k == 0) begin : g_top
            assign w_up_valid = 1'b1;
            assign w_up_tag   = w_touch_tag;
        end else begin : g_below
            assign w_up_valid = w_valid_q[k-1];
            assign w_up_tag   = w_tag_q[k-1];
        end

        falmt_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_active   (r_active[k]),
            .i_lookup   (w_touch_tag),
            .i_up_valid (w_up_valid),
            .i_up_tag   (w_up_tag),
            .o_valid    (w_valid_q[k]),
            .o_tag      (w_tag_q[k]),
            .o_hit      (w_hit_vec[k])
        );
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.miss       = r_out_miss;
    assign o_rsp.two_blocks = r_out_two;

    // A block is held by at most one active line.
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit_vec))
        else $error("More than one line hit the same block.");

    // The second lookup only happens for a pending two-line reference.
    a_second_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SECOND) |-> (r_req_vld && r_two))
        else $error("Second lookup without a pending two-line request.");

    // A register write leaves every line invalid.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_valid_q == '0))
        else $error("Lines still valid after a register write.");

    // A two-line result reports a miss of either lookup.
    a_miss_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_state == ST_SECOND) |=>
            (r_out_miss == ($past(r_miss1) || !$past(w_any_hit))))
        else $error("Two-line miss result lost a lookup.");

endmodule
